// File: hdl/ille_pkg.sv
package ille_pkg;
  localparam int unsigned Capacity = 256;
  localparam int unsigned SlotW = 9;
  localparam int unsigned AddrW = 8;
  localparam logic [SlotW-1:0] SlotNone = 9'd256;

  typedef enum logic [3:0] {
    ACT_INS_FIRST  = 4'd0,
    ACT_INS_AFTER  = 4'd1,
    ACT_INS_BEFORE = 4'd2,
    ACT_ERASE      = 4'd3,
    ACT_ERASE_RUN  = 4'd4,
    ACT_CLEAR      = 4'd5,
    ACT_FAST_CLEAR = 4'd6,
    ACT_REVERSE    = 4'd7,
    ACT_QUERY      = 4'd8
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_RANGE     = 3'd2,
    ST_COUNT     = 3'd3,
    ST_NOT_EMPTY = 3'd4
  } status_e;

  typedef struct packed {
    logic [3:0]       action;
    logic [AddrW-1:0] index;
    logic [SlotW-1:0] count;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [SlotW-1:0] new_slot;
    logic [SlotW-1:0] next_slot;
    logic [SlotW-1:0] prev_slot;
    logic [SlotW-1:0] front_slot;
    logic [SlotW-1:0] back_slot;
    logic [SlotW-1:0] list_size;
  } rsp_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,     // register request, read fwd/bwd of index
    OP_READ_CUR,  // read fwd/bwd of cursor
    OP_EXEC,      // single-entry command commit
    OP_WALK,      // erase-run check walk step
    OP_KILL,      // erase-run clear live bit of cursor, step
    OP_RUN_FIN,   // erase-run relink
    OP_RUN_FIX,   // erase-run second neighbor write
    OP_CLR_STEP,  // clear: write one slot
    OP_REV_STEP,  // reverse: swap cursor links
    OP_FIN,       // finalize head/tail after clear/reverse
    OP_SECOND,    // second write of insert/erase
    OP_READ_FREE, // read fwd of free head
    OP_RUN_START  // erase-run: rewind cursor to the run start
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic [3:0] action;
    logic       idx_live;
    logic       full;
    logic       cnt_zero;
    logic       cnt_big;
    logic       cur_none;
    logic       walk_done;
    logic       size_le1;
    logic       hw_zero;
    logic       clr_done;
    logic       tail_none;
    logic       need_second;
  } sts_t;
endpackage

// File: hdl/indexed_linked_list_engine_core.sv
// Indexed linked-list engine.
// Requests enter on req_valid_i/req_ready_o carrying action, index and count.
// Each request yields exactly one response on rsp_valid_o/rsp_ready_i with
// status, new slot, queried links and the list's front, back and size.
// Requests are handled one at a time: the link tables have one read address
// and registered reads, so a single-entry command passes through latch,
// index read, free-head read and execute states before its response, with a
// second write state for inserts and erase.
// Erase run first walks the run to check that it stays inside the list,
// then walks it again from its start clearing each entry, and relinks.
// Reverse walks the whole list swapping each entry's links; clear writes
// one slot per cycle up to the high-water mark.
// The response register holds its value while the receiver stalls, and no
// new request is taken until the response has been delivered.
// Reset empties the list and the free list and zeroes the high-water mark;
// the link tables are not cleared, since no entry is read before written.
module indexed_linked_list_engine_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  ille_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output ille_pkg::rsp_t rsp_o
);
  import ille_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ille_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  ille_datapath u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts), .rsp_o
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_o && rsp_valid_o)) else $error("ready while response pending");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed under stall");
  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.list_size <= SlotW'(Capacity)) else $error("size exceeds capacity");
endmodule

// File: hdl/ille_datapath.sv
module ille_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ille_pkg::req_t  req_i,
  input  ille_pkg::cmd_t  cmd_i,
  output ille_pkg::sts_t  sts_o,
  output ille_pkg::rsp_t  rsp_o
);
  import ille_pkg::*;

  logic [SlotW-1:0] fwd_mem [Capacity];
  logic [SlotW-1:0] bwd_mem [Capacity];
  logic [Capacity-1:0] live_q, live_d;

  logic [SlotW-1:0] head_q, head_d, tail_q, tail_d, free_q, free_d;
  logic [SlotW-1:0] hw_q, hw_d, size_q, size_d;
  req_t             req_q;
  logic [SlotW-1:0] cur_q, cur_d, last_q, last_d, n_q, n_d, slot_q, slot_d;
  logic [SlotW-1:0] rf_q, rb_q, a_q, a_d, b_q, b_d;
  logic [2:0]       st_q, st_d;
  logic [SlotW-1:0] nxt_q, nxt_d, prv_q, prv_d;
  logic             sec_q, sec_d;
  logic [SlotW-1:0] sec_addr_q, sec_addr_d, sec_val_q, sec_val_d;
  logic             sec_fwd_q, sec_fwd_d;

  // One write per table per cycle, one read address per cycle.
  logic             wf_en, wb_en;
  logic [AddrW-1:0] wf_addr, wb_addr, rd_addr;
  logic [SlotW-1:0] wf_val, wb_val;

  logic [SlotW-1:0] idx9, newslot;
  logic             full;

  assign idx9    = {1'b0, req_q.index};
  assign full    = (free_q == SlotNone) && (hw_q >= SlotW'(Capacity));
  assign newslot = (free_q != SlotNone) ? free_q : hw_q;

  always_comb begin
    head_d = head_q; tail_d = tail_q; free_d = free_q; hw_d = hw_q;
    size_d = size_q; live_d = live_q; cur_d = cur_q; last_d = last_q;
    n_d = n_q; slot_d = slot_q; a_d = a_q; b_d = b_q; st_d = st_q;
    nxt_d = nxt_q; prv_d = prv_q; sec_d = 1'b0; sec_addr_d = sec_addr_q;
    sec_val_d = sec_val_q; sec_fwd_d = sec_fwd_q;
    wf_en = 1'b0; wb_en = 1'b0; wf_addr = '0; wb_addr = '0; wf_val = '0; wb_val = '0;
    rd_addr = cur_q[AddrW-1:0];
    case (cmd_i.op)
      OP_LATCH: begin
        rd_addr = req_i.index;
        st_d = ST_OK; slot_d = SlotNone; nxt_d = SlotNone; prv_d = SlotNone;
        cur_d = {1'b0, req_i.index}; n_d = 9'd1;
        last_d = {1'b0, req_i.index};
      end
      OP_READ_CUR: rd_addr = cur_q[AddrW-1:0];
      OP_READ_FREE: rd_addr = free_q[AddrW-1:0];
      OP_RUN_START: begin
        cur_d = idx9; n_d = '0;
      end
      OP_EXEC: begin
        case (req_q.action)
          ACT_INS_FIRST: begin
            if (size_q != '0) st_d = ST_NOT_EMPTY;
            else if (full) st_d = ST_FULL;
            else begin
              // The new slot is the free-list head if there is one, else the high-water mark.
              slot_d = newslot;
              if (free_q != SlotNone) free_d = rf_q; else hw_d = hw_q + 9'd1;
              live_d[newslot[AddrW-1:0]] = 1'b1; size_d = size_q + 9'd1;
              wf_en = 1'b1; wf_addr = newslot[AddrW-1:0]; wf_val = SlotNone;
              wb_en = 1'b1; wb_addr = newslot[AddrW-1:0]; wb_val = SlotNone;
              head_d = newslot; tail_d = newslot;
            end
          end
          ACT_INS_AFTER, ACT_INS_BEFORE: begin
            if (!live_q[req_q.index]) st_d = ST_RANGE;
            else if (full) st_d = ST_FULL;
            else begin
              // a_q/b_q hold idx links; rf_q holds fwd of free head.
              slot_d = newslot;
              if (free_q != SlotNone) free_d = rf_q; else hw_d = hw_q + 9'd1;
              live_d[newslot[AddrW-1:0]] = 1'b1; size_d = size_q + 9'd1;
              if (req_q.action == ACT_INS_AFTER) begin
                wf_en = 1'b1; wf_addr = req_q.index; wf_val = newslot;
                wb_en = 1'b1; wb_addr = newslot[AddrW-1:0]; wb_val = idx9;
                sec_d = 1'b1; sec_fwd_d = 1'b1; sec_addr_d = newslot; sec_val_d = a_q;
                if (a_q == SlotNone) tail_d = newslot;
                else begin
                  sec_fwd_d = 1'b1;
                end
              end else begin
                wb_en = 1'b1; wb_addr = req_q.index; wb_val = newslot;
                wf_en = 1'b1; wf_addr = newslot[AddrW-1:0]; wf_val = idx9;
                sec_d = 1'b1; sec_fwd_d = 1'b0; sec_addr_d = newslot; sec_val_d = b_q;
                if (b_q == SlotNone) head_d = newslot;
              end
            end
          end
          ACT_ERASE: begin
            if (!live_q[req_q.index]) st_d = ST_RANGE;
            else begin
              if (b_q == SlotNone) head_d = a_q;
              else begin wf_en = 1'b1; wf_addr = b_q[AddrW-1:0]; wf_val = a_q; end
              if (a_q == SlotNone) tail_d = b_q;
              else begin wb_en = 1'b1; wb_addr = a_q[AddrW-1:0]; wb_val = b_q; end
              sec_d = 1'b1; sec_fwd_d = 1'b1; sec_addr_d = idx9; sec_val_d = free_q;
              free_d = idx9; live_d[req_q.index] = 1'b0; size_d = size_q - 9'd1;
            end
          end
          ACT_ERASE_RUN: begin
            if (!live_q[req_q.index]) st_d = ST_RANGE;
            else if (req_q.count != '0 && req_q.count > size_q) st_d = ST_COUNT;
          end
          ACT_QUERY: begin
            if (!live_q[req_q.index]) st_d = ST_RANGE;
            else begin nxt_d = a_q; prv_d = b_q; end
          end
          ACT_CLEAR: cur_d = '0;
          ACT_REVERSE: cur_d = head_q;
          ACT_FAST_CLEAR: begin
            if (tail_q != SlotNone) begin
              if (free_q != SlotNone) begin
                wf_en = 1'b1; wf_addr = tail_q[AddrW-1:0]; wf_val = free_q;
              end
              free_d = head_q; live_d = '0; head_d = SlotNone; tail_d = SlotNone;
              size_d = '0;
            end
          end
          default: ;
        endcase
      end
      OP_SECOND: begin
        if (sec_fwd_q) begin
          wf_en = 1'b1; wf_addr = sec_addr_q[AddrW-1:0]; wf_val = sec_val_q;
        end else begin
          wb_en = 1'b1; wb_addr = sec_addr_q[AddrW-1:0]; wb_val = sec_val_q;
        end
        // Neighbor write of insert: bwd(a)=s after, fwd(b)=s before.
        if (req_q.action == ACT_INS_AFTER && sec_val_q != SlotNone) begin
          wb_en = 1'b1; wb_addr = sec_val_q[AddrW-1:0]; wb_val = slot_q;
        end
        if (req_q.action == ACT_INS_BEFORE && sec_val_q != SlotNone) begin
          wf_en = 1'b1; wf_addr = sec_val_q[AddrW-1:0]; wf_val = slot_q;
        end
      end
      OP_WALK: begin
        // rf_q is fwd(last); counting n up to count.
        last_d = rf_q; n_d = n_q + 9'd1; cur_d = rf_q;
        if (rf_q == SlotNone) st_d = ST_COUNT;
      end
      OP_KILL: begin
        live_d[cur_q[AddrW-1:0]] = 1'b0; cur_d = rf_q; n_d = n_q + 9'd1;
      end
      OP_RUN_FIN: begin
        // rf_q = fwd(last), a = follower of run.
        a_d = rf_q;
        size_d = size_q - req_q.count;
        wf_en = 1'b1; wf_addr = last_q[AddrW-1:0]; wf_val = free_q;
        free_d = idx9;
        if (b_q == SlotNone) head_d = rf_q;
        else begin wb_en = 1'b0; end
        if (rf_q == SlotNone) tail_d = b_q;
        else begin wb_en = 1'b1; wb_addr = rf_q[AddrW-1:0]; wb_val = b_q; end
      end
      OP_RUN_FIX: begin
        if (b_q != SlotNone) begin
          wf_en = 1'b1; wf_addr = b_q[AddrW-1:0]; wf_val = a_q;
        end
      end
      OP_CLR_STEP: begin
        wf_en = 1'b1; wf_addr = cur_q[AddrW-1:0];
        wf_val = (cur_q + 9'd1 < hw_q) ? cur_q + 9'd1 : SlotNone;
        wb_en = 1'b1; wb_addr = cur_q[AddrW-1:0];
        wb_val = (cur_q == '0) ? SlotNone : cur_q - 9'd1;
        cur_d = cur_q + 9'd1;
      end
      OP_REV_STEP: begin
        wf_en = 1'b1; wf_addr = cur_q[AddrW-1:0]; wf_val = rb_q;
        wb_en = 1'b1; wb_addr = cur_q[AddrW-1:0]; wb_val = rf_q;
        cur_d = rf_q;
      end
      OP_FIN: begin
        if (req_q.action == ACT_CLEAR) begin
          live_d = '0; head_d = SlotNone; tail_d = SlotNone; size_d = '0; free_d = '0;
        end else begin
          head_d = tail_q; tail_d = head_q;
        end
      end
      default: ;
    endcase
  end

  // Registered reads of both tables at one address.
  always_ff @(posedge clk_i) begin
    if (wf_en) fwd_mem[wf_addr] <= wf_val;
    if (wb_en) bwd_mem[wb_addr] <= wb_val;
    rf_q <= fwd_mem[rd_addr];
    rb_q <= bwd_mem[rd_addr];
  end

  // Index links captured after latch; free-head fwd read on the next cycle.
  logic lat_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= SlotNone; tail_q <= SlotNone; free_q <= SlotNone;
      hw_q <= '0; size_q <= '0; live_q <= '0; lat_q <= 1'b0;
    end else begin
      head_q <= head_d; tail_q <= tail_d; free_q <= free_d; hw_q <= hw_d;
      size_q <= size_d; live_q <= live_d; lat_q <= (cmd_i.op == OP_LATCH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) req_q <= req_i;
    cur_q <= cur_d; last_q <= last_d; n_q <= n_d; slot_q <= slot_d;
    st_q <= st_d; nxt_q <= nxt_d; prv_q <= prv_d; sec_q <= sec_d;
    sec_addr_q <= sec_addr_d; sec_val_q <= sec_val_d; sec_fwd_q <= sec_fwd_d;
    if (lat_q) begin a_q <= rf_q; b_q <= rb_q; end
    else begin a_q <= a_d; b_q <= b_d; end
  end

  assign sts_o.action      = req_q.action;
  assign sts_o.idx_live    = live_q[req_q.index];
  assign sts_o.full        = full;
  assign sts_o.cnt_zero    = (req_q.count == '0);
  assign sts_o.cnt_big     = (req_q.count > size_q);
  assign sts_o.cur_none    = (cur_q == SlotNone) || (n_q > size_q);
  assign sts_o.walk_done   = (n_q >= req_q.count);
  assign sts_o.size_le1    = (size_q <= 9'd1);
  assign sts_o.hw_zero     = (hw_q == '0);
  assign sts_o.clr_done    = (cur_q >= hw_q);
  assign sts_o.tail_none   = (st_q == ST_COUNT);
  assign sts_o.need_second = sec_q;

  assign rsp_o.status     = st_q;
  assign rsp_o.new_slot   = slot_q;
  assign rsp_o.next_slot  = nxt_q;
  assign rsp_o.prev_slot  = prv_q;
  assign rsp_o.front_slot = head_q;
  assign rsp_o.back_slot  = tail_q;
  assign rsp_o.list_size  = size_q;
endmodule

// File: hdl/ille_ctrl.sv
module ille_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  input  ille_pkg::sts_t sts_i,
  output ille_pkg::cmd_t cmd_o
);
  import ille_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RDIDX = 10'b0000000010,
    S_RDFR  = 10'b0000000100,
    S_EXEC  = 10'b0000001000,
    S_SEC   = 10'b0000010000,
    S_WALK  = 10'b0000100000,
    S_KILL  = 10'b0001000000,
    S_LOOP  = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_RSP   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   phase_q, phase_d;

  always_comb begin
    state_d = state_q; phase_d = phase_q; cmd_o.op = OP_NOP;
    case (state_q)
      S_IDLE: if (req_valid_i) begin cmd_o.op = OP_LATCH; state_d = S_RDIDX; end
      S_RDIDX: state_d = S_RDFR;  // index links arrive, then read free head
      S_RDFR: begin cmd_o.op = OP_READ_FREE; state_d = S_EXEC; end
      S_EXEC: begin
        cmd_o.op = OP_EXEC;
        state_d = S_RSP;
        if (sts_i.action == ACT_ERASE_RUN && sts_i.idx_live && !sts_i.cnt_zero &&
            !sts_i.cnt_big) begin
          state_d = S_WALK; phase_d = 1'b0;
        end else if (sts_i.action == ACT_CLEAR && !sts_i.hw_zero) begin
          state_d = S_LOOP;
        end else if (sts_i.action == ACT_REVERSE && !sts_i.size_le1) begin
          state_d = S_LOOP; phase_d = 1'b0;
        end else if ((sts_i.action == ACT_INS_AFTER || sts_i.action == ACT_INS_BEFORE ||
                      sts_i.action == ACT_ERASE) && sts_i.idx_live &&
                     (sts_i.action == ACT_ERASE || !sts_i.full)) begin
          state_d = S_SEC;
        end
      end
      S_SEC: begin
        cmd_o.op = (sts_i.action == ACT_ERASE_RUN) ? OP_RUN_FIX : OP_SECOND;
        state_d = S_RSP;
      end
      S_WALK: begin
        // Alternate read and step, checking the run stays inside the list.
        if (sts_i.tail_none) state_d = S_RSP;
        else if (sts_i.walk_done) begin
          cmd_o.op = OP_RUN_START; state_d = S_KILL; phase_d = 1'b0;
        end else if (!phase_q) begin cmd_o.op = OP_READ_CUR; phase_d = 1'b1; end
        else begin cmd_o.op = OP_NOP; phase_d = 1'b0; state_d = S_FIN; end
      end
      S_KILL: begin
        // Second pass from the run start: wait for the link, then clear and step.
        if (sts_i.walk_done) begin
          cmd_o.op = OP_RUN_FIN; phase_d = 1'b0; state_d = S_SEC;
        end else if (!phase_q) begin cmd_o.op = OP_NOP; phase_d = 1'b1; end
        else begin cmd_o.op = OP_KILL; phase_d = 1'b0; end
      end
      S_LOOP: begin
        if (sts_i.action == ACT_CLEAR) begin
          if (sts_i.clr_done) begin cmd_o.op = OP_FIN; state_d = S_RSP; end
          else cmd_o.op = OP_CLR_STEP;
        end else begin
          if (sts_i.cur_none) begin cmd_o.op = OP_FIN; state_d = S_RSP; end
          else if (!phase_q) begin cmd_o.op = OP_READ_CUR; phase_d = 1'b1; end
          else begin cmd_o.op = OP_NOP; phase_d = 1'b0; state_d = S_FIN; end
        end
      end
      S_FIN: begin
        if (sts_i.action == ACT_REVERSE) begin cmd_o.op = OP_REV_STEP; state_d = S_LOOP; end
        else begin cmd_o.op = OP_WALK; state_d = S_WALK; end
      end
      S_RSP: if (rsp_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; phase_q <= 1'b0;
    end else begin
      state_q <= state_d; phase_q <= phase_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RSP);
endmodule

// File: test/indexed_linked_list_engine_core_checker.sv
module indexed_linked_list_engine_core_checker
  import ille_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   req_valid_i,
  input  logic   req_ready_i,
  input  req_t   req_i,
  input  logic   rsp_valid_i,
  input  logic   rsp_ready_i,
  input  rsp_t   rsp_i,
  output int     errors_o,
  output int     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [SlotW-1:0] fwd_q [Capacity];
  logic [SlotW-1:0] bwd_q [Capacity];
  bit               live_q [Capacity];
  logic [SlotW-1:0] head_q, tail_q, free_q, hw_q, size_q;
  rsp_t             expected_rsp_q [$];

  assign pending_o = expected_rsp_q.size();

  function automatic logic [SlotW-1:0] fwd_of(logic [SlotW-1:0] i);
    return (i < SlotNone) ? fwd_q[i[AddrW-1:0]] : SlotNone;
  endfunction

  function automatic logic [SlotW-1:0] bwd_of(logic [SlotW-1:0] i);
    return (i < SlotNone) ? bwd_q[i[AddrW-1:0]] : SlotNone;
  endfunction

  function automatic void set_fwd(logic [SlotW-1:0] i, logic [SlotW-1:0] v);
    if (i < SlotNone) fwd_q[i[AddrW-1:0]] = v;
  endfunction

  function automatic void set_bwd(logic [SlotW-1:0] i, logic [SlotW-1:0] v);
    if (i < SlotNone) bwd_q[i[AddrW-1:0]] = v;
  endfunction

  function automatic logic [SlotW-1:0] alloc_slot();
    logic [SlotW-1:0] s;
    if (free_q != SlotNone) begin
      s = free_q;
      free_q = fwd_of(s);
    end else begin
      s = hw_q;
      hw_q++;
    end
    if (s < SlotNone) live_q[s[AddrW-1:0]] = 1'b1;
    size_q++;
    return s;
  endfunction

  function automatic rsp_t apply_command(req_t r);
    rsp_t             o;
    logic [SlotW-1:0] idx, s, a, b, last;
    bit               live, full;
    int               n;
    o = '0;
    o.status = ST_OK;
    o.new_slot = SlotNone;
    o.next_slot = SlotNone;
    o.prev_slot = SlotNone;
    idx = {1'b0, r.index};
    live = live_q[r.index];
    full = (free_q == SlotNone) && (hw_q >= SlotNone);
    case (r.action)
      ACT_INS_FIRST: begin
        if (size_q != 0) o.status = ST_NOT_EMPTY;
        else if (full) o.status = ST_FULL;
        else begin
          s = alloc_slot();
          set_fwd(s, SlotNone);
          set_bwd(s, SlotNone);
          head_q = s;
          tail_q = s;
          o.new_slot = s;
        end
      end
      ACT_INS_AFTER, ACT_INS_BEFORE: begin
        if (!live) o.status = ST_RANGE;
        else if (full) o.status = ST_FULL;
        else begin
          s = alloc_slot();
          o.new_slot = s;
          if (r.action == ACT_INS_AFTER) begin
            a = fwd_of(idx);
            set_fwd(idx, s); set_fwd(s, a); set_bwd(s, idx);
            if (a == SlotNone) tail_q = s; else set_bwd(a, s);
          end else begin
            b = bwd_of(idx);
            set_bwd(idx, s); set_fwd(s, idx); set_bwd(s, b);
            if (b == SlotNone) head_q = s; else set_fwd(b, s);
          end
        end
      end
      ACT_ERASE: begin
        if (!live) o.status = ST_RANGE;
        else begin
          b = bwd_of(idx);
          a = fwd_of(idx);
          if (b == SlotNone) head_q = a; else set_fwd(b, a);
          if (a == SlotNone) tail_q = b; else set_bwd(a, b);
          set_fwd(idx, free_q);
          free_q = idx;
          live_q[r.index] = 1'b0;
          size_q--;
        end
      end
      ACT_ERASE_RUN: begin
        if (!live) o.status = ST_RANGE;
        else if (r.count == 0) begin
        end else if (r.count > size_q) o.status = ST_COUNT;
        else begin
          last = idx;
          for (n = 1; n < r.count && last != SlotNone; n++) last = fwd_of(last);
          if (last == SlotNone) o.status = ST_COUNT;
          else begin
            s = idx;
            for (n = 0; n < r.count; n++) begin
              if (s < SlotNone) live_q[s[AddrW-1:0]] = 1'b0;
              s = fwd_of(s);
            end
            size_q -= r.count;
            a = fwd_of(last);
            set_fwd(last, free_q);
            free_q = idx;
            b = bwd_of(idx);
            if (b == SlotNone) head_q = a; else set_fwd(b, a);
            if (a == SlotNone) tail_q = b; else set_bwd(a, b);
          end
        end
      end
      ACT_CLEAR: begin
        if (hw_q != 0) begin
          for (n = 0; n < hw_q && n < Capacity; n++) begin
            fwd_q[n] = (n + 1 < hw_q) ? SlotW'(n + 1) : SlotNone;
            bwd_q[n] = (n == 0) ? SlotNone : SlotW'(n - 1);
          end
          foreach (live_q[k]) live_q[k] = 1'b0;
          head_q = SlotNone; tail_q = SlotNone; size_q = 0;
          free_q = 0;
        end
      end
      ACT_FAST_CLEAR: begin
        if (tail_q != SlotNone) begin
          if (free_q != SlotNone) set_fwd(tail_q, free_q);
          free_q = head_q;
          foreach (live_q[k]) live_q[k] = 1'b0;
          head_q = SlotNone; tail_q = SlotNone; size_q = 0;
        end
      end
      ACT_REVERSE: begin
        if (size_q > 1) begin
          s = head_q;
          for (n = 0; n < size_q && s != SlotNone; n++) begin
            a = fwd_of(s);
            set_fwd(s, bwd_of(s));
            set_bwd(s, a);
            s = a;
          end
          s = head_q; head_q = tail_q; tail_q = s;
        end
      end
      ACT_QUERY: begin
        if (!live) o.status = ST_RANGE;
        else begin
          o.next_slot = fwd_of(idx);
          o.prev_slot = bwd_of(idx);
        end
      end
      default: begin
      end
    endcase
    o.front_slot = head_q;
    o.back_slot = tail_q;
    o.list_size = size_q;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      foreach (live_q[k]) live_q[k] = 1'b0;
      head_q = SlotNone; tail_q = SlotNone; free_q = SlotNone;
      hw_q = 0; size_q = 0;
      errors_o = 0;
      expected_rsp_q.delete();
    end else begin
      // Responses are checked before the same edge's request is predicted.
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response with no request outstanding");
          errors_o++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_i.status);
            errors_o++;
          end
          if (rsp_i.new_slot !== want.new_slot) begin
            $error("new_slot: expected %0d, got %0d", want.new_slot, rsp_i.new_slot);
            errors_o++;
          end
          if (rsp_i.next_slot !== want.next_slot) begin
            $error("next_slot: expected %0d, got %0d", want.next_slot, rsp_i.next_slot);
            errors_o++;
          end
          if (rsp_i.prev_slot !== want.prev_slot) begin
            $error("prev_slot: expected %0d, got %0d", want.prev_slot, rsp_i.prev_slot);
            errors_o++;
          end
          if (rsp_i.front_slot !== want.front_slot) begin
            $error("front_slot: expected %0d, got %0d", want.front_slot,
                   rsp_i.front_slot);
            errors_o++;
          end
          if (rsp_i.back_slot !== want.back_slot) begin
            $error("back_slot: expected %0d, got %0d", want.back_slot, rsp_i.back_slot);
            errors_o++;
          end
          if (rsp_i.list_size !== want.list_size) begin
            $error("list_size: expected %0d, got %0d", want.list_size, rsp_i.list_size);
            errors_o++;
          end
        end
      end
      if (req_valid_i && req_ready_i) expected_rsp_q.push_back(apply_command(req_i));
    end
  end
endmodule

// File: test/indexed_linked_list_engine_core_test.sv
module indexed_linked_list_engine_core_test;
  import ille_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  int   errors;
  int   pending;
  bit   long_stall = 1'b0;

  // Shadow of which slots are live, so most random requests name real entries.
  bit   live_mirror [Capacity];
  int   live_slots [$];

  always #6 clk_i = ~clk_i;

  indexed_linked_list_engine_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .rsp_valid_o(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_o(rsp)
  );

  indexed_linked_list_engine_core_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid), .req_ready_i(req_ready), .req_i(req),
    .rsp_valid_i(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_i(rsp),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (rsp_valid && rsp_ready && rsp.status == ST_OK) begin
      if (rsp.new_slot != SlotNone) live_mirror[rsp.new_slot[AddrW-1:0]] <= 1'b1;
    end
  end

  task automatic send_request(logic [3:0] act, logic [AddrW-1:0] idx,
                              logic [SlotW-1:0] cnt);
    req_valid <= 1'b1;
    req.action <= act;
    req.index <= idx;
    req.count <= cnt;
    @(posedge clk_i);
    while (!req_ready) @(posedge clk_i);
    req_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [AddrW-1:0] pick_index();
    live_slots.delete();
    foreach (live_mirror[k]) if (live_mirror[k]) live_slots.push_back(k);
    if (live_slots.size() == 0 || $urandom_range(9) == 0) return AddrW'($urandom);
    return AddrW'(live_slots[$urandom_range(live_slots.size() - 1)]);
  endfunction

  // The mirror only tracks inserts; wipe it whenever the list may shrink.
  task automatic refresh_after(logic [3:0] act);
    if (act inside {ACT_ERASE, ACT_ERASE_RUN, ACT_CLEAR, ACT_FAST_CLEAR}) begin
      drain();
      foreach (live_mirror[k]) live_mirror[k] = 1'b0;
    end
  endtask

  initial begin
    int w;
    forever begin
      @(posedge clk_i);
      if (long_stall) begin
        rsp_ready <= 1'b0;
        for (w = 0; w < 200; w++) @(posedge clk_i);
        long_stall = 1'b0;
      end
      case ($urandom_range(3))
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= ($urandom_range(3) != 0);
        2: rsp_ready <= ($urandom_range(1) != 0);
        default: rsp_ready <= ($urandom_range(4) == 0);
      endcase
    end
  end

  initial begin
    #40ms;
    $display("indexed_linked_list_engine_core_test: FAIL");
    $finish;
  end

  initial begin
    int i, burst, gap, g, k;
    logic [3:0] act;
    logic [AddrW-1:0] idx;
    logic [SlotW-1:0] cnt;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    send_request(ACT_QUERY, 8'd0, 9'd0);
    send_request(ACT_CLEAR, 8'd0, 9'd0);
    send_request(ACT_FAST_CLEAR, 8'd0, 9'd0);
    send_request(ACT_REVERSE, 8'd0, 9'd0);
    send_request(ACT_INS_FIRST, 8'd0, 9'd0);
    send_request(ACT_INS_FIRST, 8'd0, 9'd0);
    send_request(ACT_INS_AFTER, 8'd0, 9'd0);
    send_request(ACT_INS_BEFORE, 8'd0, 9'd0);
    send_request(ACT_INS_AFTER, 8'd255, 9'd0);
    send_request(ACT_REVERSE, 8'd0, 9'd0);
    send_request(ACT_QUERY, 8'd0, 9'd0);
    send_request(ACT_ERASE_RUN, 8'd0, 9'd0);
    send_request(ACT_ERASE_RUN, 8'd0, 9'd256);
    send_request(ACT_ERASE_RUN, 8'd1, 9'd3);
    send_request(ACT_ERASE_RUN, 8'd0, 9'd2);
    send_request(4'd15, 8'd255, 9'h1FF);
    send_request(4'd9, 8'd170, 9'h0AA);
    send_request(ACT_ERASE, 8'd1, 9'd0);
    send_request(ACT_FAST_CLEAR, 8'd0, 9'd0);
    send_request(ACT_INS_FIRST, 8'd0, 9'd0);
    send_request(ACT_ERASE, 8'd2, 9'd0);
    send_request(ACT_CLEAR, 8'd0, 9'd0);
    drain();

    // Fill the whole table to reach the full status, then clear it again.
    send_request(ACT_INS_FIRST, 8'd0, 9'd0);
    for (k = 0; k < Capacity + 2; k++) send_request(ACT_INS_AFTER, 8'd0, 9'd0);
    send_request(ACT_INS_BEFORE, 8'd0, 9'd0);
    send_request(ACT_REVERSE, 8'd0, 9'd0);
    send_request(ACT_ERASE_RUN, 8'd0, 9'd256);
    send_request(ACT_CLEAR, 8'd0, 9'd0);
    drain();

    // Receiver holds off while the sender keeps offering requests.
    long_stall = 1'b1;
    send_request(ACT_INS_FIRST, 8'd0, 9'd0);
    for (k = 0; k < 6; k++) send_request(ACT_INS_AFTER, 8'd0, 9'd0);
    drain();

    i = 0;
    while (i < 300) begin
      burst = $urandom_range(12, 1);
      for (g = 0; g < burst; g++) begin
        k = $urandom_range(99);
        idx = pick_index();
        cnt = 9'($urandom_range(4));
        if (k < 5) act = ACT_INS_FIRST;
        else if (k < 35) act = ACT_INS_AFTER;
        else if (k < 55) act = ACT_INS_BEFORE;
        else if (k < 63) act = ACT_ERASE;
        else if (k < 69) act = ACT_ERASE_RUN;
        else if (k < 71) act = ACT_CLEAR;
        else if (k < 73) act = ACT_FAST_CLEAR;
        else if (k < 78) act = ACT_REVERSE;
        else if (k < 97) act = ACT_QUERY;
        else begin
          act = 4'($urandom);
          cnt = 9'($urandom);
        end
        if (act == ACT_INS_FIRST) begin
          drain();
          foreach (live_mirror[j]) live_mirror[j] = 1'b0;
        end
        if (act == ACT_ERASE_RUN && $urandom_range(9) == 0) cnt = 9'($urandom);
        send_request(act, idx, cnt);
        refresh_after(act);
        i++;
      end
      gap = $urandom_range(3) == 0 ? 0 : $urandom_range(8);
      for (g = 0; g < gap; g++) @(posedge clk_i);
    end

    drain();
    repeat (3000) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("indexed_linked_list_engine_core_test: PASS");
    end else begin
      $display("indexed_linked_list_engine_core_test: FAIL");
    end
    $finish;
  end
endmodule
